>>> rtl/spmc_pkg.sv
package spmc_pkg;

    // Angle is held in 1/64 degree: 11520 stands for 180 degrees.
    localparam int unsigned ANGLE_W    = 14;
    localparam int unsigned PULSE_W    = 15;
    localparam int unsigned STEP_W     = 11;
    localparam int unsigned JOY_W      = 10;
    localparam int unsigned CMD_W      = 2;
    localparam int unsigned CFG_IDX_W  = 8;
    localparam int unsigned CFG_DATA_W = 15;
    localparam int unsigned S_DATA_W   = 16;
    localparam int unsigned M_DATA_W   = 32;

    localparam logic [ANGLE_W-1:0] ANGLE_FULL = 14'd11520;
    localparam logic [ANGLE_W-1:0] ANGLE_MID  = 14'd5760;
    localparam logic [PULSE_W-1:0] PERIOD_US  = 15'd20000;

    // Manual scaling: joy * 11520 / 1023 = 11 * joy + joy * 267 / 1023.
    localparam logic [ANGLE_W-1:0] JOY_INT_MUL  = 14'd11;
    localparam logic [18:0]        JOY_FRAC_MUL = 19'd267;
    localparam logic [10:0]        JOY_FULL     = 11'd1023;

    // Pulse scaling: divide by 11520 as a shift by 8 and a divide by 45.
    // The reciprocal ceil(2^27 / 45) is exact for every 21 bit dividend.
    localparam int unsigned        PULSE_PRE_SHIFT = 8;
    localparam int unsigned        RECIP_SHIFT     = 27;
    localparam logic [42:0]        RECIP_45        = 43'd2982617;

    // Register reset values.
    localparam logic [STEP_W-1:0]  TRACK_STEP_RST = 11'd32;
    localparam logic [PULSE_W-1:0] MIN_PULSE_RST  = 15'd1000;
    localparam logic [PULSE_W-1:0] SPAN_RST       = 15'd1000;

    // Register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_TRACK_STEP = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_PULSE  = 8'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PULSE_SPAN = 8'd2;

    // Tracking commands; the unused code holds like none.
    typedef enum logic [CMD_W-1:0] {
        CMD_NONE  = 2'd0,
        CMD_LEFT  = 2'd1,
        CMD_RIGHT = 2'd2
    } track_cmd_t;

endpackage

>>> rtl/servo_pan_mode_controller.sv
// Servo pan mode controller. Each input beat stands for one servo period and
// gives exactly one result beat. A rising edge of the trigger toggles between
// manual mode (angle follows the joystick X reading scaled to 0..180 degrees)
// and tracking mode (left steps the angle up, right steps it down, none holds).
// The angle, in 1/64 degree, is clamped to 0..11520 and mapped to a pulse
// width of the minimum pulse plus angle * pulse span / 11520, saturated at
// 20000 us. The block takes one beat per cycle unless a stage is stalled; a result
// beat is offered once its input beat has passed the input register, the
// mode and angle update, the span multiplier, the reciprocal divide by 45
// and the saturating output adder. Each stage stalls only while the stage after
// it is full and blocked.
// Configuration writes are taken in every cycle and must be made while idle.
module servo_pan_mode_controller (
    input  logic                                aclk,
    input  logic                                aresetn,
    // Input channel. tdata: trigger[0], joy_x[10:1], track_cmd[12:11].
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [spmc_pkg::S_DATA_W-1:0]       s_tdata,
    // Result channel. tdata: pulse_width[14:0], tracking_mode[15], angle_q[29:16].
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [spmc_pkg::M_DATA_W-1:0]       m_tdata,
    // Configuration write channel.
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [spmc_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [spmc_pkg::CFG_DATA_W-1:0]     cfg_data
);

    // Configuration registers.
    logic [spmc_pkg::STEP_W-1:0]  track_step_reg;
    logic [spmc_pkg::PULSE_W-1:0] min_pulse_reg;
    logic [spmc_pkg::PULSE_W-1:0] span_reg;

    // Stage valid bits and readies.
    logic v0_reg, v1_reg, v2_reg, v3_reg, v4_reg;
    logic r0, r1, r2, r3, r4;

    // Stage 0: input register.
    logic                          trig0_reg;
    logic [spmc_pkg::JOY_W-1:0]    joy0_reg;
    logic [spmc_pkg::CMD_W-1:0]    cmd0_reg;

    // Stage 1: the controller state doubles as the stage payload.
    logic                          mode_reg, mode_next;
    logic                          last_trig_reg;
    logic [spmc_pkg::ANGLE_W-1:0]  angle_reg, angle_next;

    // Stage 2: span product.
    logic [28:0]                   prod2_reg;
    logic                          mode2_reg;
    logic [spmc_pkg::ANGLE_W-1:0]  angle2_reg;

    // Stage 3: quotient of the product by 11520.
    logic [15:0]                   quot3_reg;
    logic                          mode3_reg;
    logic [spmc_pkg::ANGLE_W-1:0]  angle3_reg;

    // Stage 4: output register.
    logic [spmc_pkg::PULSE_W-1:0]  pulse4_reg;
    logic                          mode4_reg;
    logic [spmc_pkg::ANGLE_W-1:0]  angle4_reg;

    // Intermediate values.
    logic [18:0]                   joy_frac;
    logic [8:0]                    joy_q0;
    logic [10:0]                   joy_rem;
    logic [spmc_pkg::ANGLE_W-1:0]  manual_angle;
    logic [14:0]                   step_sum;
    logic [spmc_pkg::ANGLE_W-1:0]  step_angle;
    logic [42:0]                   recip_prod;
    logic [16:0]                   pulse_sum;

    // Each stage is free when empty or when the next one takes its beat.
    assign r4       = !v4_reg || m_tready;
    assign r3       = !v3_reg || r4;
    assign r2       = !v2_reg || r3;
    assign r1       = !v1_reg || r2;
    assign r0       = !v0_reg || r1;
    assign s_tready = r0;
    assign m_tvalid = v4_reg;
    assign m_tdata  = {2'b00, angle4_reg, mode4_reg, pulse4_reg};
    assign cfg_ready = 1'b1;

    // Configuration writes; unknown indexes are dropped.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            track_step_reg <= spmc_pkg::TRACK_STEP_RST;
            min_pulse_reg  <= spmc_pkg::MIN_PULSE_RST;
            span_reg       <= spmc_pkg::SPAN_RST;
        end else if (cfg_valid) begin
            case (cfg_index)
                spmc_pkg::CFG_TRACK_STEP: track_step_reg <= cfg_data[spmc_pkg::STEP_W-1:0];
                spmc_pkg::CFG_MIN_PULSE:  min_pulse_reg  <= cfg_data;
                spmc_pkg::CFG_PULSE_SPAN: span_reg       <= cfg_data;
                default: ;
            endcase
        end
    end

    // Manual angle: 11 * joy plus joy * 267 / 1023, where the quotient
    // estimate from a shift by ten is at most one short.
    always_comb begin
        joy_frac     = 19'(joy0_reg) * spmc_pkg::JOY_FRAC_MUL;
        joy_q0       = joy_frac[18:10];
        joy_rem      = 11'(joy_frac[9:0]) + 11'(joy_q0);
        manual_angle = 14'(joy0_reg) * spmc_pkg::JOY_INT_MUL + 14'(joy_q0)
                     + ((joy_rem >= spmc_pkg::JOY_FULL) ? 14'd1 : 14'd0);
    end

    // Mode toggle on the trigger edge, then the angle update in the new mode.
    always_comb begin
        mode_next  = mode_reg ^ (trig0_reg && !last_trig_reg);
        step_sum   = 15'(angle_reg);
        case (cmd0_reg)
            spmc_pkg::CMD_LEFT:  step_sum = 15'(angle_reg) + 15'(track_step_reg);
            spmc_pkg::CMD_RIGHT: step_sum = (angle_reg > 14'(track_step_reg))
                                          ? 15'(angle_reg - 14'(track_step_reg)) : 15'd0;
            default:             step_sum = 15'(angle_reg);
        endcase
        step_angle = (step_sum > 15'(spmc_pkg::ANGLE_FULL)) ? spmc_pkg::ANGLE_FULL
                                                            : step_sum[13:0];
        angle_next = mode_next ? step_angle : manual_angle;
    end

    // Division of the shifted product by 45 through its reciprocal.
    assign recip_prod = 43'(prod2_reg[28:spmc_pkg::PULSE_PRE_SHIFT]) * spmc_pkg::RECIP_45;

    // Offset and saturation at the period.
    assign pulse_sum = 17'(min_pulse_reg) + 17'(quot3_reg);

    // Valid bits and controller state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v0_reg        <= 1'b0;
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
            v4_reg        <= 1'b0;
            mode_reg      <= 1'b0;
            last_trig_reg <= 1'b0;
            angle_reg     <= spmc_pkg::ANGLE_MID;
        end else begin
            if (r0) v0_reg <= s_tvalid;
            if (r1) v1_reg <= v0_reg;
            if (r2) v2_reg <= v1_reg;
            if (r3) v3_reg <= v2_reg;
            if (r4) v4_reg <= v3_reg;
            if (v0_reg && r1) begin
                mode_reg      <= mode_next;
                last_trig_reg <= trig0_reg;
                angle_reg     <= angle_next;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        if (r0) begin
            trig0_reg <= s_tdata[0];
            joy0_reg  <= s_tdata[10:1];
            cmd0_reg  <= s_tdata[12:11];
        end
        if (r2) begin
            prod2_reg  <= 29'(angle_reg) * 29'(span_reg);
            mode2_reg  <= mode_reg;
            angle2_reg <= angle_reg;
        end
        if (r3) begin
            quot3_reg  <= recip_prod[42:spmc_pkg::RECIP_SHIFT];
            mode3_reg  <= mode2_reg;
            angle3_reg <= angle2_reg;
        end
        if (r4) begin
            pulse4_reg <= (pulse_sum > 17'(spmc_pkg::PERIOD_US)) ? spmc_pkg::PERIOD_US
                                                                 : pulse_sum[14:0];
            mode4_reg  <= mode3_reg;
            angle4_reg <= angle3_reg;
        end
    end

    // The held angle never leaves the 0..180 degree range.
    a_angle_range: assert property (@(posedge aclk) disable iff (!aresetn)
        angle_reg <= spmc_pkg::ANGLE_FULL)
        else $error("angle left its range");

    // A trigger edge taken into the state flips the mode.
    a_mode_toggle: assert property (@(posedge aclk) disable iff (!aresetn)
        (v0_reg && r1 && trig0_reg && !last_trig_reg) |=> (mode_reg != $past(mode_reg)))
        else $error("trigger edge did not toggle the mode");

    // Without a trigger edge the mode holds.
    a_mode_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        !(v0_reg && r1 && trig0_reg && !last_trig_reg) |=> $stable(mode_reg))
        else $error("mode changed without a trigger edge");

    // A result beat never exceeds the servo period.
    a_pulse_sat: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[14:0] <= spmc_pkg::PERIOD_US))
        else $error("pulse width beyond the period");

endmodule

>>> tb/servo_pan_mode_controller_test.sv
`timescale 1ns / 1ps

module servo_pan_mode_controller_test;
    import spmc_pkg::*;

    localparam int LATENCY = 4;
    // The one command code that has no name in the package; it holds like none.
    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
    // A register index past the end of the register list.
    localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED = 8'd3;

    typedef struct packed {
        logic [PULSE_W-1:0] pulse_width;
        logic               tracking_mode;
        logic [ANGLE_W-1:0] angle_q;
    } servo_result_t;

    logic                  aclk;
    logic                  aresetn;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [S_DATA_W-1:0]   s_tdata;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [M_DATA_W-1:0]   m_tdata;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    // Expected servo results, oldest first.
    servo_result_t expected_servo[$];

    // Our own copy of the controller state and its registers.
    logic               model_mode;
    logic               model_last_trig;
    logic [ANGLE_W-1:0] model_angle;
    logic [STEP_W-1:0]  model_step;
    logic [PULSE_W-1:0] model_min_pulse;
    logic [PULSE_W-1:0] model_span;

    int error_count;
    int periods_sent;
    int src_gap_max;
    int sink_stall_max;

    servo_pan_mode_controller u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // 100 MHz clock.
    initial aclk = 1'b0;
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // State of the controller right after reset.
    function automatic void reset_model();
        model_mode      = 1'b0;
        model_last_trig = 1'b0;
        model_angle     = ANGLE_MID;
        model_step      = TRACK_STEP_RST;
        model_min_pulse = MIN_PULSE_RST;
        model_span      = SPAN_RST;
    endfunction

    // Advance the controller state by one servo period and return its result.
    function automatic servo_result_t predict_period(input logic trig,
                                                     input logic [JOY_W-1:0] joy,
                                                     input logic [CMD_W-1:0] cmd);
        int unsigned   next_angle;
        int unsigned   pulse;
        servo_result_t r;
        // The trigger edge comes first, so the angle update sees the new mode.
        if (trig && !model_last_trig) model_mode = ~model_mode;
        model_last_trig = trig;
        next_angle = model_angle;
        if (!model_mode) begin
            next_angle = (32'(joy) * 32'(ANGLE_FULL)) / 32'(JOY_FULL);
        end else if (cmd == CMD_RIGHT) begin
            next_angle = (next_angle > model_step) ? next_angle - model_step : 0;
        end else if (cmd == CMD_LEFT) begin
            next_angle = next_angle + model_step;
        end
        if (next_angle > ANGLE_FULL) next_angle = ANGLE_FULL;
        model_angle = ANGLE_W'(next_angle);
        pulse = model_min_pulse + (next_angle * model_span) / ANGLE_FULL;
        if (pulse > PERIOD_US) pulse = PERIOD_US;
        r.pulse_width   = PULSE_W'(pulse);
        r.tracking_mode = model_mode;
        r.angle_q       = model_angle;
        return r;
    endfunction

    // Joystick reading with the two ends of the travel drawn more often.
    function automatic logic [JOY_W-1:0] rand_joy();
        int pick;
        pick = $urandom_range(0, 7);
        if (pick == 0) return '0;
        if (pick == 1) return JOY_W'(1023);
        return JOY_W'($urandom_range(0, 1023));
    endfunction

    // Send one servo period as one beat, after a random gap.
    task automatic send_period(input logic trig, input logic [JOY_W-1:0] joy,
                               input logic [CMD_W-1:0] cmd);
        int gap;
        gap = (src_gap_max == 0) ? 0 : $urandom_range(0, src_gap_max);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= S_DATA_W'({cmd, joy, trig});
        do @(posedge aclk); while (!s_tready);
        expected_servo.push_back(predict_period(trig, joy, cmd));
        periods_sent++;
    endtask

    // Write one register; the block must be idle.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_index <= idx;
        cfg_data  <= data;
        cfg_valid <= 1'b1;
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            CFG_TRACK_STEP: model_step      = data[STEP_W-1:0];
            CFG_MIN_PULSE:  model_min_pulse = data;
            CFG_PULSE_SPAN: model_span      = data;
            default: ;
        endcase
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    // Stop sending and let every outstanding result come back.
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (expected_servo.size() != 0) @(posedge aclk);
        repeat (LATENCY + 2) @(posedge aclk);
    endtask

    // Produce a rising trigger edge so the mode flips.
    task automatic toggle_mode();
        if (model_last_trig) send_period(1'b0, rand_joy(), CMD_W'($urandom_range(0, 3)));
        send_period(1'b1, rand_joy(), CMD_W'($urandom_range(0, 3)));
    endtask

    // Manual scaling at both ends and alternating bits, then mode toggles and
    // every command, with the trigger held high once so no edge is seen.
    task automatic test_manual_and_toggle();
        send_period(1'b0, 10'd0, CMD_NONE);
        send_period(1'b0, 10'd1023, CMD_LEFT);
        send_period(1'b0, 10'd341, CMD_RIGHT);
        send_period(1'b0, 10'd682, CMD_UNUSED);
        send_period(1'b1, 10'd100, CMD_LEFT);
        send_period(1'b1, 10'd900, CMD_RIGHT);
        send_period(1'b0, 10'd0, CMD_NONE);
        send_period(1'b0, 10'd1023, CMD_UNUSED);
        send_period(1'b1, 10'd512, CMD_LEFT);
    endtask

    // A step so large it hits both angle limits, and a pulse past the period.
    task automatic test_limits_and_saturation();
        wait_idle();
        // Only the low bits of the step register are kept.
        write_reg(CFG_TRACK_STEP, 15'h7FFF);
        write_reg(CFG_MIN_PULSE, 15'd19000);
        write_reg(CFG_PULSE_SPAN, 15'd20000);
        send_period(1'b0, 10'd1023, CMD_NONE);
        send_period(1'b1, 10'd0, CMD_LEFT);
        repeat (6) send_period(1'b0, 10'd1023, CMD_RIGHT);
        send_period(1'b0, 10'd1023, CMD_RIGHT);
    endtask

    // A zero step holds the angle; a write past the register list changes nothing.
    task automatic test_zero_step_and_unmapped();
        wait_idle();
        write_reg(CFG_TRACK_STEP, 15'd0);
        write_reg(CFG_UNMAPPED, 15'h7FFF);
        write_reg(CFG_IDX_W'($urandom_range(4, 255)), CFG_DATA_W'($urandom));
        send_period(1'b0, 10'd700, CMD_LEFT);
        send_period(1'b0, 10'd300, CMD_RIGHT);
    endtask

    // One setting of the registers, then runs of tracking, manual and noise.
    task automatic run_random_phase(input logic [CFG_DATA_W-1:0] step_word,
                                    input logic [CFG_DATA_W-1:0] min_word,
                                    input logic [CFG_DATA_W-1:0] span_word,
                                    input int n_periods, input bit pause_midway);
        int               start;
        int               kind;
        int               run_len;
        int               pick;
        bit               paused;
        logic [CMD_W-1:0] dir;
        logic [CMD_W-1:0] cmd_now;
        wait_idle();
        write_reg(CFG_TRACK_STEP, step_word);
        write_reg(CFG_MIN_PULSE, min_word);
        write_reg(CFG_PULSE_SPAN, span_word);
        start  = periods_sent;
        paused = 1'b0;
        while (periods_sent - start < n_periods) begin
            if (pause_midway && !paused && periods_sent - start >= n_periods / 2) begin
                wait_idle();
                paused = 1'b1;
            end
            src_gap_max    = ($urandom_range(0, 3) == 0) ? 0 : 7;
            sink_stall_max = ($urandom_range(0, 3) == 0) ? 0 : 7;
            kind = $urandom_range(0, 9);
            if (kind <= 5) begin
                // Tracking run: mostly one direction so the limits are reached.
                if (!model_mode) toggle_mode();
                dir = $urandom_range(0, 1) ? CMD_LEFT : CMD_RIGHT;
                run_len = $urandom_range(1, 40);
                repeat (run_len) begin
                    pick = $urandom_range(0, 9);
                    cmd_now = (pick < 8) ? dir : ((pick == 8) ? CMD_NONE : CMD_UNUSED);
                    send_period(1'b0, rand_joy(), cmd_now);
                end
            end else if (kind <= 7) begin
                // Manual run: the angle follows the joystick.
                if (model_mode) toggle_mode();
                run_len = $urandom_range(1, 20);
                repeat (run_len) send_period(1'b0, rand_joy(), CMD_W'($urandom_range(0, 3)));
            end else begin
                // Noise: random trigger levels and commands.
                run_len = $urandom_range(1, 10);
                repeat (run_len) begin
                    send_period(1'($urandom_range(0, 1)), rand_joy(),
                                CMD_W'($urandom_range(0, 3)));
                end
            end
        end
    endtask

    // Several register settings, the extremes among them.
    task automatic test_random_settings();
        run_random_phase(15'd32, 15'd1000, 15'd1000, 145, 1'b0);
        run_random_phase(15'd1, 15'd0, 15'd0, 145, 1'b0);
        run_random_phase(15'd1024, 15'd20000, 15'd20000, 145, 1'b1);
        run_random_phase(15'h7FFF, 15'h7FFF, 15'd20000, 145, 1'b0);
        run_random_phase(15'd0, 15'd500, 15'h7FFF, 145, 1'b0);
        run_random_phase(CFG_DATA_W'($urandom_range(1, 1024)),
                         CFG_DATA_W'($urandom_range(0, 20000)),
                         CFG_DATA_W'($urandom_range(0, 20000)), 145, 1'b0);
        run_random_phase(CFG_DATA_W'($urandom_range(1, 2047)),
                         CFG_DATA_W'($urandom_range(0, 20000)),
                         CFG_DATA_W'($urandom_range(0, 20000)), 145, 1'b0);
    endtask

    // Result side: random stalls, and each beat checked against the oldest
    // expected result.
    initial begin : result_checker
        servo_result_t got;
        servo_result_t want;
        int            stall;
        m_tready = 1'b0;
        wait (aresetn === 1'b1);
        forever begin
            stall = (sink_stall_max == 0) ? 0 : $urandom_range(0, sink_stall_max);
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
            got.pulse_width   = m_tdata[14:0];
            got.tracking_mode = m_tdata[15];
            got.angle_q       = m_tdata[29:16];
            if (expected_servo.size() == 0) begin
                if (error_count < 10) begin
                    $display("unexpected result beat: pulse %0d mode %0d angle %0d",
                             got.pulse_width, got.tracking_mode, got.angle_q);
                end
                error_count++;
            end else begin
                want = expected_servo.pop_front();
                if (got.pulse_width != want.pulse_width ||
                    got.tracking_mode != want.tracking_mode ||
                    got.angle_q != want.angle_q) begin
                    if (error_count < 10) begin
                        $display({"mismatch: expected pulse %0d mode %0d angle %0d, ",
                                  "got pulse %0d mode %0d angle %0d"},
                                 want.pulse_width, want.tracking_mode, want.angle_q,
                                 got.pulse_width, got.tracking_mode, got.angle_q);
                    end
                    error_count++;
                end
            end
        end
    end

    // Main sequence.
    initial begin : main_sequence
        int wait_cycles;
        aresetn        = 1'b0;
        s_tvalid       = 1'b0;
        s_tdata        = '0;
        cfg_valid      = 1'b0;
        cfg_index      = '0;
        cfg_data       = '0;
        error_count    = 0;
        periods_sent   = 0;
        src_gap_max    = 7;
        sink_stall_max = 7;
        reset_model();
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_manual_and_toggle();
        test_limits_and_saturation();
        test_zero_step_and_unmapped();
        test_random_settings();

        // Drain with a bound, then give stray beats a chance to show up.
        s_tvalid <= 1'b0;
        wait_cycles = 0;
        while (expected_servo.size() != 0 && wait_cycles < 4000) begin
            @(posedge aclk);
            wait_cycles++;
        end
        repeat (LATENCY + 2) @(posedge aclk);
        if (expected_servo.size() != 0) begin
            $display("%0d expected results never arrived", expected_servo.size());
        end
        if (error_count == 0 && expected_servo.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

    // Hard limit on the run time.
    initial begin : watchdog
        #2_000_000;
        $display("TEST FAILED");
        $finish;
    end

endmodule
